/* sv/bsde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsde_pkg
// Shared types and constants of the bitmap shape draw engine.
// ---------------------------------------------------------------------------
package bsde_pkg;

   localparam int MaxWidth  = 64;
   localparam int MaxHeight = 64;
   localparam int RowAw     = $clog2(MaxHeight);

   localparam logic [1:0] REQ_SQUARE   = 2'd0;
   localparam logic [1:0] REQ_LINE     = 2'd1;
   localparam logic [1:0] REQ_TRIANGLE = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAW,
      ST_EMIT,
      ST_FAIL
   } state_type;

   // one straight run of pixels: start, step and count
   typedef struct packed {
      logic signed [9:0] col;
      logic signed [9:0] row;
      logic signed [1:0] dc;
      logic signed [1:0] dr;
      logic [8:0]        cnt;
   } seg_type;

endpackage
`default_nettype wire

/* sv/bsde_seg_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsde_seg_check
// Checks that both end points of a run of pixels lie on the board.
// ---------------------------------------------------------------------------
module bsde_seg_check (
   input  wire bsde_pkg::seg_type seg,
   input  wire logic [6:0]        bw,
   input  wire logic [6:0]        bh,
   output logic                   ok
);
   import bsde_pkg::*;

   logic signed [10:0] ec;
   logic signed [10:0] er;
   logic signed [10:0] n1;

   // end point: start + step * (count - 1)
   always_comb begin
      n1 = $signed({2'b00, seg.cnt}) - 11'sd1;
      ec = 11'(seg.col) + (seg.dc == 2'sd1 ? n1 : (seg.dc == -2'sd1 ? -n1 : 11'sd0));
      er = 11'(seg.row) + (seg.dr == 2'sd1 ? n1 : (seg.dr == -2'sd1 ? -n1 : 11'sd0));
      ok = (seg.cnt == 9'd0) ||
           (seg.col >= 0 && ec >= 0 && 11'(seg.col) < $signed({4'd0, bw}) &&
            ec < $signed({4'd0, bw}) && seg.row >= 0 && er >= 0 &&
            11'(seg.row) < $signed({4'd0, bh}) && er < $signed({4'd0, bh}));
   end

endmodule
`default_nettype wire

/* sv/bitmap_shape_draw_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_shape_draw_engine
// One-bit pixel map that draws squares, lines and triangle outlines and
// emits the whole map after each successful request.
// ---------------------------------------------------------------------------
//  channel | ports                              | handshake
//  request | req_*                              | start & !busy
//  result  | rsp_*                              | rsp_valid, per row
//  config  | csr_we, csr_index, csr_wdata       | csr_we
//
//  Steps: each run is checked in turn (up to 3), then one row read-modify-write per
//  cycle while drawing (up to 64, or 192 for a triangle), then one row per
//  cycle emitted. A clear request sweeps all 64 rows. The single row port
//  of the map memory sets the rate. Synchronous reset; the map reset value
//  is made by a 64-entry valid bit vector. The receiver cannot stall.
// ---------------------------------------------------------------------------
module bitmap_shape_draw_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_x_pos,
   input  wire logic [7:0]  req_y_pos,
   input  wire logic [7:0]  req_x_end,
   input  wire logic [7:0]  req_y_end,
   input  wire logic [6:0]  req_shape_size,
   input  wire logic        req_tri_vertical,
   input  wire logic        req_tri_horizontal,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [5:0]       rsp_row_index,
   output logic [63:0]      rsp_row_bits,
   output logic             rsp_last
);
   import bsde_pkg::*;

   state_type state_ff, state_in;
   logic [6:0] bwreg_ff, bwreg_in, bhreg_ff, bhreg_in;
   logic [6:0] bw, bh;
   seg_type    segs_ff [3];
   seg_type    segs_in [3];
   logic [1:0] sidx_ff, sidx_in;   // run under work
   logic [1:0] nseg_ff, nseg_in;
   logic       clr_ff, clr_in;
   logic       ok;
   seg_type    cur;
   // draw position inside current run
   logic signed [9:0] pc_ff, pc_in, pr_ff, pr_in;
   logic [8:0]        left_ff, left_in;
   logic [6:0]        erow_ff, erow_in;
   logic [MaxHeight-1:0] vld_ff, vld_in;
   logic [63:0] mem [MaxHeight];
   logic [63:0] rd;
   logic        we;
   logic [RowAw-1:0] waddr;
   logic [63:0] wdata;
   logic [63:0] mask;
   logic signed [8:0] sx, sy, dx, dy, ax, ay, nn;
   logic [6:0]  s1;
   logic        slant;

   assign bw = (bwreg_ff == 7'd0) ? 7'd1 : (bwreg_ff > 7'd64 ? 7'd64 : bwreg_ff);
   assign bh = (bhreg_ff == 7'd0) ? 7'd1 : (bhreg_ff > 7'd64 ? 7'd64 : bhreg_ff);
   assign cur = segs_ff[sidx_ff];

   bsde_seg_check u_chk (.seg(cur), .bw(bw), .bh(bh), .ok(ok));

   // config registers
   always_comb begin
      bwreg_in = bwreg_ff;
      bhreg_in = bhreg_ff;
      if (csr_we && csr_index == CSR_WIDTH) bwreg_in = csr_wdata;
      if (csr_we && csr_index == CSR_HEIGHT) bhreg_in = csr_wdata;
   end

   // request decode into up to three runs
   always_comb begin
      sx = 9'(signed'(req_x_pos));
      sy = 9'(signed'(req_y_pos));
      dx = 9'(signed'(req_x_end)) - sx;
      dy = 9'(signed'(req_y_end)) - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      nn = ax > ay ? ax : ay;
      slant = (dx != 0) && (dy != 0) && (ax != ay);
      s1 = req_shape_size - 7'd1;
      for (int i = 0; i < 3; i++) segs_in[i] = segs_ff[i];
      nseg_in = nseg_ff;
      clr_in  = clr_ff;
      if (state_ff == ST_IDLE && start) begin
         clr_in = (req_type == REQ_CLEAR);
         segs_in[0] = '0; segs_in[1] = '0; segs_in[2] = '0;
         nseg_in = 2'd1;
         case (req_type)
            REQ_SQUARE: begin
               // one horizontal run per row is drawn; the check uses the corners
               segs_in[0] = '{col: 10'(sx), row: 10'(sy), dc: 2'sd1, dr: 2'sd1,
                              cnt: {2'b00, req_shape_size}};
            end
            REQ_LINE: begin
               // a slanted line starts off the board so the check rejects it
               segs_in[0] = '{col: slant ? -10'sd1 : 10'(sx), row: 10'(sy),
                              dc: dx > 0 ? 2'sd1 : (dx < 0 ? -2'sd1 : 2'sd0),
                              dr: dy > 0 ? 2'sd1 : (dy < 0 ? -2'sd1 : 2'sd0),
                              cnt: 9'(nn) + 9'd1};
            end
            REQ_TRIANGLE: begin
               // an empty triangle has no runs to draw
               nseg_in = (req_shape_size == 7'd0) ? 2'd0 : 2'd3;
               segs_in[0] = '{col: 10'(sx), row: 10'(sy), dc: 2'sd0,
                              dr: req_tri_vertical ? 2'sd1 : -2'sd1,
                              cnt: {2'b00, req_shape_size}};
               segs_in[1] = '{col: 10'(sx), row: 10'(sy),
                              dc: req_tri_horizontal ? 2'sd1 : -2'sd1, dr: 2'sd0,
                              cnt: {2'b00, req_shape_size}};
               segs_in[2] = '{col: req_tri_horizontal ? 10'(sx) + 10'(s1)
                                                     : 10'(sx) - 10'(s1),
                              row: 10'(sy),
                              dc: req_tri_horizontal ? -2'sd1 : 2'sd1,
                              dr: req_tri_vertical ? 2'sd1 : -2'sd1,
                              cnt: {2'b00, req_shape_size}};
            end
            default: begin
               nseg_in = 2'd0;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            if (clr_ff) state_in = ST_DRAW;
            else if (segs_ff[0].dc != 2'sd0 && segs_ff[0].dr != 2'sd0 &&
                     nseg_ff == 2'd1 && sidx_ff == 2'd0 &&
                     cur.cnt == 9'd0) state_in = ST_FAIL;
            else if (!ok) state_in = ST_FAIL;
            else if (sidx_ff == nseg_ff - 2'd1 || nseg_ff == 2'd0) state_in = ST_DRAW;
         end
         ST_DRAW: if (clr_ff ? left_ff == 9'd1 : (left_ff <= 9'd1 &&
                       (sidx_ff == nseg_ff - 2'd1 || nseg_ff == 2'd0)))
                     state_in = ST_EMIT;
         ST_EMIT: if (erow_ff == 7'(bh) - 7'd1) state_in = ST_IDLE;
         ST_FAIL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // square flag: a run with both steps on that came from a square
   logic sq_ff, sq_in;

   // datapath sequencing
   always_comb begin
      sidx_in = sidx_ff;
      pc_in = pc_ff; pr_in = pr_ff; left_in = left_ff;
      erow_in = erow_ff;
      sq_in = sq_ff;
      we = 1'b0; waddr = pr_ff[RowAw-1:0]; wdata = rd;
      vld_in = vld_ff;
      case (state_ff)
         ST_IDLE: begin
            sidx_in = 2'd0;
            sq_in = (req_type == REQ_SQUARE);
            erow_in = 7'd0;
         end
         ST_CHECK: begin
            if (state_in == ST_DRAW) begin
               sidx_in = 2'd0;
               pc_in = segs_ff[0].col; pr_in = segs_ff[0].row;
               left_in = clr_ff ? 9'd64 : (nseg_ff == 2'd0 ? 9'd0 : segs_ff[0].cnt);
            end else begin
               sidx_in = sidx_ff + 2'd1;
            end
         end
         ST_DRAW: begin
            if (clr_ff) begin
               we = 1'b1; waddr = 6'(left_ff - 9'd1); wdata = '0;
               vld_in[6'(left_ff - 9'd1)] = 1'b1;
               left_in = left_ff - 9'd1;
            end else if (left_ff != 9'd0) begin
               // read data for row pr_ff is valid; set pixels and write back
               we = 1'b1;
               if (sq_ff)
                  wdata = rd | (((64'd1 << cur.cnt[6:0]) - 64'd1) << pc_ff[5:0]);
               else
                  wdata = rd | (64'd1 << pc_ff[5:0]);
               vld_in[waddr] = 1'b1;
               left_in = left_ff - 9'd1;
               pc_in = sq_ff ? pc_ff : pc_ff + 10'(cur.dc);
               pr_in = pr_ff + (sq_ff ? 10'sd1 : 10'(cur.dr));
               if (left_ff == 9'd1 && sidx_ff != nseg_ff - 2'd1) begin
                  sidx_in = sidx_ff + 2'd1;
                  pc_in = segs_ff[sidx_ff + 2'd1].col;
                  pr_in = segs_ff[sidx_ff + 2'd1].row;
                  left_in = segs_ff[sidx_ff + 2'd1].cnt;
               end
            end
         end
         ST_EMIT: erow_in = erow_ff + 7'd1;
         default: ;
      endcase
   end

   // the map read address is taken from next-state values, so the read leads the write
   logic [RowAw-1:0] raddr;
   logic [63:0] rdm_ff;
   logic        rv_ff;
   always_comb begin
      raddr = (state_in == ST_EMIT) ? erow_in[RowAw-1:0] : pr_in[RowAw-1:0];
   end
   assign rd = rv_ff ? rdm_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdm_ff <= (we && waddr == raddr) ? wdata : mem[raddr];
   end

   // row write hazard: a run revisiting the same row uses forwarded data
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bwreg_ff <= 7'd64;
         bhreg_ff <= 7'd64;
         vld_ff   <= '0;
         rv_ff    <= 1'b0;
         sidx_ff  <= '0;
         nseg_ff  <= '0;
         erow_ff  <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bwreg_ff <= bwreg_in;
         bhreg_ff <= bhreg_in;
         vld_ff   <= vld_in;
         rv_ff    <= vld_in[raddr];
         sidx_ff  <= sidx_in;
         nseg_ff  <= nseg_in;
         erow_ff  <= erow_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) segs_ff[i] <= segs_in[i];
      clr_ff <= clr_in;
      pc_ff  <= pc_in;
      pr_ff  <= pr_in;
      sq_ff  <= sq_in;
   end

   // outputs
   always_comb begin
      mask = (bw >= 7'd64) ? '1 : ((64'd1 << bw[5:0]) - 64'd1);
      busy = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_FAIL);
      rsp_status = (state_ff == ST_FAIL);
      rsp_row_index = (state_ff == ST_EMIT) ? erow_ff[5:0] : 6'd0;
      rsp_row_bits = (state_ff == ST_EMIT) ? (rd & mask) : 64'd0;
      rsp_last = (state_ff == ST_FAIL) || (erow_ff == 7'(bh) - 7'd1);
   end

endmodule
`default_nettype wire

/* tb/bitmap_shape_draw_engine_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_shape_draw_engine_test
// Drives squares, lines, triangles and clears into the draw engine under
// several board sizes and checks every emitted row against a local pixel map.
// ---------------------------------------------------------------------------
module bitmap_shape_draw_engine_test;
   import bsde_pkg::*;

   typedef struct packed {
      logic        status;
      logic [5:0]  row_index;
      logic [63:0] row_bits;
      logic        last;
   } row_out_t;

   // pixel map predictor and queue of expected rows
   class draw_board;
      logic [63:0] map_rows [64];
      logic [63:0] trial [64];
      logic [6:0]  width_reg;
      logic [6:0]  height_reg;
      row_out_t    pending [$];
      int          errors;
      int          rows_seen;
      int          rejects;

      function void clear_all();
         foreach (map_rows[i]) map_rows[i] = '0;
         width_reg  = 7'd64;
         height_reg = 7'd64;
      endfunction

      function int dim(logic [6:0] v);
         if (v < 1) return 1;
         if (v > 64) return 64;
         return int'(v);
      endfunction

      // plot a run of n pixels into the trial copy; 0 when any is off board
      function bit paint(int c, int r, int dc, int dr, int n, int w, int h);
         int k;
         int cc;
         int rr;
         for (k = 0; k < n; k++) begin
            cc = c + dc * k;
            rr = r + dr * k;
            if (cc < 0 || cc >= w || rr < 0 || rr >= h) return 0;
            trial[rr][cc] = 1'b1;
         end
         return 1;
      endfunction

      function void note_item(logic [1:0] kind, logic signed [7:0] xs, logic signed [7:0] ys,
                              logic signed [7:0] xe, logic signed [7:0] ye,
                              logic [6:0] sz, logic dn, logic rt);
         int w;
         int h;
         int x;
         int y;
         int dx;
         int dy;
         int adx;
         int ady;
         int s;
         int vd;
         int hd;
         bit ok;
         row_out_t o;
         logic [63:0] msk;
         w = dim(width_reg);
         h = dim(height_reg);
         x = xs;
         y = ys;
         s = sz;
         ok = 1;
         trial = map_rows;
         case (kind)
            REQ_SQUARE: begin
               if (s == 0) ok = 0;
               for (int r = 0; ok && r < s; r++) ok = paint(x, y + r, 1, 0, s, w, h);
            end
            REQ_LINE: begin
               dx = int'(xe) - x;
               dy = int'(ye) - y;
               adx = dx < 0 ? -dx : dx;
               ady = dy < 0 ? -dy : dy;
               if (dx != 0 && dy != 0 && adx != ady) ok = 0;
               else ok = paint(x, y, (dx > 0) - (dx < 0), (dy > 0) - (dy < 0),
                               (adx > ady ? adx : ady) + 1, w, h);
            end
            REQ_TRIANGLE: begin
               if (s > 0) begin
                  vd = dn ? 1 : -1;
                  hd = rt ? 1 : -1;
                  ok = paint(x, y, 0, vd, s, w, h);
                  if (ok) ok = paint(x, y, hd, 0, s, w, h);
                  if (ok) ok = paint(x + hd * (s - 1), y, -hd, vd, s, w, h);
               end
            end
            default: foreach (trial[i]) trial[i] = '0;
         endcase
         if (!ok) begin
            rejects++;
            o = '{status: 1'b1, row_index: '0, row_bits: '0, last: 1'b1};
            pending.push_back(o);
            return;
         end
         map_rows = trial;
         msk = (w >= 64) ? '1 : ((64'd1 << w) - 1);
         for (int r = 0; r < h; r++) begin
            o = '{status: 1'b0, row_index: r[5:0], row_bits: map_rows[r] & msk,
                  last: (r == h - 1)};
            pending.push_back(o);
         end
      endfunction

      function void check_row(row_out_t got);
         row_out_t want;
         rows_seen++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected row %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("row mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_type = '0;
   logic [7:0] req_x_pos = '0, req_y_pos = '0, req_x_end = '0, req_y_end = '0;
   logic [6:0] req_shape_size = '0;
   logic req_tri_vertical = 0, req_tri_horizontal = 0;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [6:0] csr_wdata = '0;
   logic rsp_valid, rsp_status, rsp_last;
   logic [5:0] rsp_row_index;
   logic [63:0] rsp_row_bits;

   draw_board board = new();
   int cycles = 0;
   int items_sent = 0;

   bitmap_shape_draw_engine dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_row('{rsp_status, rsp_row_index, rsp_row_bits, rsp_last});
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(logic [1:0] kind, logic [7:0] xs, logic [7:0] ys,
                            logic [7:0] xe, logic [7:0] ye, logic [6:0] sz,
                            logic dn, logic rt);
      req_type <= kind;
      req_x_pos <= xs;
      req_y_pos <= ys;
      req_x_end <= xe;
      req_y_end <= ye;
      req_shape_size <= sz;
      req_tri_vertical <= dn;
      req_tri_horizontal <= rt;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(kind, xs, ys, xe, ye, sz, dn, rt);
      items_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   // wait for all rows, then settle before a register write
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) board.width_reg = val;
      else board.height_reg = val;
      @(posedge clock);
   endtask

   // random shape, mostly fitting a board of w by h
   task automatic random_item(int w, int h);
      logic [1:0] kind;
      int x;
      int y;
      int d;
      int sel;
      logic [7:0] xe;
      logic [7:0] ye;
      kind = $urandom_range(0, 9) == 0 ? REQ_CLEAR : 2'($urandom_range(0, 2));
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
      d = $urandom_range(0, 12);
      sel = $urandom_range(0, 4);
      xe = 8'(x + (sel == 1 ? 0 : ($urandom_range(0, 1) ? d : -d)));
      ye = 8'(y + (sel == 0 ? 0 : ($urandom_range(0, 1) ? d : -d)));
      if (sel == 4) begin
         xe = 8'($urandom);
         ye = 8'($urandom);
      end
      if ($urandom_range(0, 7) == 0) begin
         x = int'(8'($urandom));
         y = int'(8'($urandom));
      end
      send_item(kind, 8'(x), 8'(y), xe, ye,
                7'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 8)),
                1'($urandom), 1'($urandom));
      idle_gap();
   endtask

   initial begin
      int w;
      int h;
      board.clear_all();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every request kind, the special cases
      send_item(REQ_SQUARE, 8'd0, 8'd0, 0, 0, 7'd1, 0, 0);
      send_item(REQ_SQUARE, 8'd62, 8'd62, 0, 0, 7'd2, 0, 0);
      send_item(REQ_SQUARE, 8'd0, 8'd0, 0, 0, 7'd0, 0, 0);       // zero size
      send_item(REQ_SQUARE, 8'd63, 8'd63, 0, 0, 7'd2, 0, 0);     // off board
      send_item(REQ_SQUARE, 8'h80, 8'h7f, 8'hff, 8'hff, 7'h7f, 1, 1);
      send_item(REQ_SQUARE, 8'd0, 8'd0, 0, 0, 7'd64, 0, 0);      // full board
      send_item(REQ_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 7'h7f, 1, 1);
      send_item(REQ_LINE, 8'd0, 8'd5, 8'd63, 8'd5, 0, 0, 0);
      send_item(REQ_LINE, 8'd9, 8'd63, 8'd9, 8'd0, 0, 0, 0);
      send_item(REQ_LINE, 8'd40, 8'd10, 8'd20, 8'd30, 0, 0, 0);  // leftward diagonal
      send_item(REQ_LINE, 8'd3, 8'd3, 8'd3, 8'd3, 0, 0, 0);
      send_item(REQ_LINE, 8'd0, 8'd0, 8'd5, 8'd2, 0, 0, 0);      // slanted
      send_item(REQ_LINE, 8'hff, 8'd0, 8'd4, 8'd0, 0, 0, 0);     // starts off board
      send_item(REQ_TRIANGLE, 8'd30, 8'd30, 0, 0, 7'd5, 0, 0);
      send_item(REQ_TRIANGLE, 8'd30, 8'd30, 0, 0, 7'd5, 1, 1);
      send_item(REQ_TRIANGLE, 8'd10, 8'd50, 0, 0, 7'd6, 0, 1);
      send_item(REQ_TRIANGLE, 8'd50, 8'd10, 0, 0, 7'd6, 1, 0);
      send_item(REQ_TRIANGLE, 8'd1, 8'd1, 0, 0, 7'd0, 0, 0);     // zero size draws nothing
      send_item(REQ_TRIANGLE, 8'd2, 8'd2, 0, 0, 7'd4, 0, 0);     // runs off the top
      drain();

      // phases over board sizes, extremes and saturation included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin w = 1; h = 1; end
            1: begin w = 7; h = 5; end
            2: begin w = $urandom_range(2, 63); h = $urandom_range(2, 63); end
            3: begin w = 64; h = 3; end
            4: begin w = 20; h = 64; end
            default: begin w = 64; h = 64; end
         endcase
         write_reg(CSR_WIDTH, (ph == 5) ? 7'h7f : 7'(w));
         write_reg(CSR_HEIGHT, (ph == 0) ? 7'd0 : 7'(h));
         repeat (40) random_item(w, h);
         drain();
      end

      $display("covered %0d items, %0d rows checked, %0d rejected shapes",
               items_sent, board.rows_seen, board.rejects);
      $display("board sizes from 1x1 to 64x64, register saturation included");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
